/* rtl/core/dtdn_pkg.sv */
// shared types, constants and calendar helpers for the date to day number unit
package dtdn_pkg;

	// field widths
	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int SERIAL_W = 22;
	localparam int YDAY_W   = 9;
	localparam int WDAY_W   = 3;
	localparam int ORDER_W  = 2;

	// highest year accepted as valid
	localparam int MAX_YEAR = 9999;

	// divide by 100 as multiply by 5243 and shift by 19, exact for 14-bit years
	localparam int CENT_W     = 8;
	localparam int CENT_MUL   = 5243;
	localparam int CENT_SHIFT = 19;
	localparam int CENT_PW    = YEAR_W + 13;
	localparam int QUART_W    = YEAR_W - 2;

	// order codes
	localparam logic [ORDER_W-1:0] ORD_EARLIER = 2'd0;
	localparam logic [ORDER_W-1:0] ORD_SAME    = 2'd1;
	localparam logic [ORDER_W-1:0] ORD_LATER   = 2'd2;
	localparam logic [ORDER_W-1:0] ORD_INVALID = 2'd3;

	// input word
	typedef struct packed {
		logic [YEAR_W-1:0]  year_a;
		logic [MONTH_W-1:0] month_a;
		logic [DAY_W-1:0]   day_a;
		logic [YEAR_W-1:0]  year_b;
		logic [MONTH_W-1:0] month_b;
		logic [DAY_W-1:0]   day_b;
	} item_t;

	// result word
	typedef struct packed {
		logic                valid_a;
		logic                valid_b;
		logic [SERIAL_W-1:0] serial_a;
		logic [YDAY_W-1:0]   year_day_a;
		logic [WDAY_W-1:0]   weekday_a;
		logic [ORDER_W-1:0]  order;
	} result_t;

	// per-date checks that do not yet depend on the leap rule
	typedef struct packed {
		logic              range_ok;
		logic              len_ok;
		logic              feb29;
		logic [YEAR_W-1:0] year;
		logic [CENT_W-1:0] cent;
	} date_chk_t;

	// first stage word
	typedef struct packed {
		date_chk_t           chk_a;
		date_chk_t           chk_b;
		logic [MONTH_W-1:0]  month_a;
		logic [DAY_W-1:0]    day_a;
		logic [SERIAL_W-1:0] base365;
		logic [QUART_W-1:0]  quart_p;
		logic [CENT_W-1:0]   cent_p;
		logic                a_lt_b;
		logic                a_eq_b;
	} front_t;

	// second stage word
	typedef struct packed {
		logic                valid_a;
		logic                valid_b;
		logic [ORDER_W-1:0]  order;
		logic [YDAY_W-1:0]   year_day;
		logic [SERIAL_W-1:0] partial;
	} mid_t;

	// quotient by 100 of a 14-bit value
	function automatic logic [CENT_W-1:0] div100(input logic [YEAR_W-1:0] v);
		logic [CENT_PW-1:0] prod;
		prod = CENT_PW'(v) * CENT_PW'(CENT_MUL);
		return CENT_W'(prod >> CENT_SHIFT);
	endfunction

	// days in a month of a common year, zero for months that do not exist
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                       len = 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

	// days before the first of a month in a common year
	function automatic logic [YDAY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
		logic [YDAY_W-1:0] n;
		case (m)
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

	// range and month length checks of one date
	function automatic date_chk_t check_date(input logic [YEAR_W-1:0] y,
			input logic [MONTH_W-1:0] m, input logic [DAY_W-1:0] d);
		date_chk_t c;
		c.range_ok = (y != '0) && (int'(y) <= MAX_YEAR) && (m >= 4'd1) && (m <= 4'd12)
			&& (d != '0);
		c.len_ok   = (d <= month_len(m));
		c.feb29    = (m == 4'd2) && (d == 5'd29);
		c.year     = y;
		c.cent     = div100(y);
		return c;
	endfunction

	// leap rule from the year and its quotient by 100
	function automatic logic is_leap(input logic [YEAR_W-1:0] y, input logic [CENT_W-1:0] q);
		logic [YEAR_W-1:0] back;
		back = YEAR_W'(q) * YEAR_W'(100);
		return (y[1:0] == 2'b00) && ((back != y) || (q[1:0] == 2'b00));
	endfunction

endpackage

/* rtl/core/dtdn_split.sv */
// stage 1: date range checks, century quotients, year base and date compare
module dtdn_split (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  dtdn_pkg::item_t item,
	output logic            valid_s1,
	output dtdn_pkg::front_t front_s1
);
	import dtdn_pkg::*;

	logic [YEAR_W-1:0] prev_year;
	front_t            front_d;

	// checks and products for both dates
	always_comb begin
		prev_year       = item.year_a - YEAR_W'(1);
		front_d.chk_a   = check_date(item.year_a, item.month_a, item.day_a);
		front_d.chk_b   = check_date(item.year_b, item.month_b, item.day_b);
		front_d.month_a = item.month_a;
		front_d.day_a   = item.day_a;
		front_d.base365 = SERIAL_W'(prev_year) * SERIAL_W'(365);
		front_d.quart_p = QUART_W'(prev_year >> 2);
		front_d.cent_p  = div100(prev_year);
		front_d.a_lt_b  = {item.year_a, item.month_a, item.day_a}
			< {item.year_b, item.month_b, item.day_b};
		front_d.a_eq_b  = {item.year_a, item.month_a, item.day_a}
			== {item.year_b, item.month_b, item.day_b};
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		front_s1 <= front_d;
	end

endmodule

/* rtl/core/dtdn_decide.sv */
// stage 2: leap rule, validity, day of year, order and leap day partial sum
module dtdn_decide (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  dtdn_pkg::front_t front_s1,
	output logic             valid_s2,
	output dtdn_pkg::mid_t   mid_s2
);
	import dtdn_pkg::*;

	logic leap_a;
	logic leap_b;
	logic ok_a;
	logic ok_b;
	mid_t mid_d;

	// validity, order, day of year and days before the year
	always_comb begin
		leap_a = is_leap(front_s1.chk_a.year, front_s1.chk_a.cent);
		leap_b = is_leap(front_s1.chk_b.year, front_s1.chk_b.cent);
		ok_a   = front_s1.chk_a.range_ok
			&& (front_s1.chk_a.len_ok || (front_s1.chk_a.feb29 && leap_a));
		ok_b   = front_s1.chk_b.range_ok
			&& (front_s1.chk_b.len_ok || (front_s1.chk_b.feb29 && leap_b));
		mid_d.valid_a = ok_a;
		mid_d.valid_b = ok_b;
		if (!(ok_a && ok_b)) begin
			mid_d.order = ORD_INVALID;
		end else if (front_s1.a_lt_b) begin
			mid_d.order = ORD_EARLIER;
		end else if (front_s1.a_eq_b) begin
			mid_d.order = ORD_SAME;
		end else begin
			mid_d.order = ORD_LATER;
		end
		if (ok_a) begin
			mid_d.year_day = days_before(front_s1.month_a) + YDAY_W'(front_s1.day_a)
				+ YDAY_W'((front_s1.month_a > 4'd2) && leap_a);
		end else begin
			mid_d.year_day = '0;
		end
		mid_d.partial = front_s1.base365 + SERIAL_W'(front_s1.quart_p)
			- SERIAL_W'(front_s1.cent_p) + SERIAL_W'(front_s1.cent_p >> 2);
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		mid_s2 <= mid_d;
	end

endmodule

/* rtl/core/dtdn_total.sv */
// stage 3: serial day count of date A, zero when invalid
module dtdn_total (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s2,
	input  dtdn_pkg::mid_t    mid_s2,
	output logic              valid_s3,
	output dtdn_pkg::result_t total_s3
);
	import dtdn_pkg::*;

	result_t total_d;

	// final add
	always_comb begin
		total_d.valid_a    = mid_s2.valid_a;
		total_d.valid_b    = mid_s2.valid_b;
		total_d.year_day_a = mid_s2.year_day;
		total_d.weekday_a  = '0;
		total_d.order      = mid_s2.order;
		if (mid_s2.valid_a) begin
			total_d.serial_a = mid_s2.partial + SERIAL_W'(mid_s2.year_day);
		end else begin
			total_d.serial_a = '0;
		end
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		total_s3 <= total_d;
	end

endmodule

/* rtl/core/dtdn_weekday.sv */
// stage 4: weekday as serial mod 7 by folding octal digits
module dtdn_weekday (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s3,
	input  dtdn_pkg::result_t total_s3,
	output logic              valid_s4,
	output dtdn_pkg::result_t result_s4
);
	import dtdn_pkg::*;

	localparam int DIGITS = (SERIAL_W + 2) / 3;
	localparam int PAD_W  = DIGITS * 3;

	logic [PAD_W-1:0] padded;
	logic [5:0]       sum1;
	logic [3:0]       sum2;
	logic [3:0]       sum3;
	logic [2:0]       rem;
	result_t          result_d;

	// 8 is 1 mod 7, so octal digits sum to the same residue
	always_comb begin
		padded = PAD_W'(total_s3.serial_a);
		sum1   = '0;
		for (int i = 0; i < DIGITS; i++) begin
			sum1 = sum1 + 6'(padded[3*i +: 3]);
		end
		sum2 = 4'(sum1[5:3]) + 4'(sum1[2:0]);
		sum3 = 4'(sum2[3]) + 4'(sum2[2:0]);
		rem  = (sum3 >= 4'd7) ? 3'(sum3 - 4'd7) : sum3[2:0];
		result_d           = total_s3;
		result_d.weekday_a = rem;
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		result_s4 <= result_d;
	end

endmodule

/* rtl/core/date_to_day_number_unit.sv */
// top level of the proleptic Gregorian date to serial day number unit
//
// Each input word holds two dates, A and B, as year, month and day. A word is
// taken at a rising edge where start is high and busy is low; busy is always
// low, so a word may be offered in every cycle.
// The result word appears on result with done high for exactly one cycle,
// once the word has passed the stage registers, and the stream keeps input order.
// Throughput is one word per cycle; each word passes four pipeline stages:
// range checks and century quotients, leap rule and order, serial sum,
// and the weekday fold.
// For each date the result says whether it is a real calendar date; for A it
// gives the serial day count (0001-01-01 is day 1), the day of year and the
// weekday (0 is Sunday), all zero when A is invalid. order tells whether A is
// earlier than, the same as or later than B, or marks an invalid date.
// Reset clears the stage valid bits, so no done strobe follows reset until a
// new word is taken. The receiver cannot stall; results are never held.
module date_to_day_number_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  dtdn_pkg::item_t   item,
	output logic              done,
	output dtdn_pkg::result_t result
);
	import dtdn_pkg::*;

	logic    take;
	logic    valid_s1;
	logic    valid_s2;
	logic    valid_s3;
	logic    valid_s4;
	front_t  front_s1;
	mid_t    mid_s2;
	result_t total_s3;
	result_t result_s4;

	// the pipeline never backs up
	assign busy = 1'b0;
	assign take = start && !busy;

	// stages
	dtdn_split u_split (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (take),
		.item     (item),
		.valid_s1 (valid_s1),
		.front_s1 (front_s1)
	);

	dtdn_decide u_decide (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.front_s1 (front_s1),
		.valid_s2 (valid_s2),
		.mid_s2   (mid_s2)
	);

	dtdn_total u_total (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.mid_s2   (mid_s2),
		.valid_s3 (valid_s3),
		.total_s3 (total_s3)
	);

	dtdn_weekday u_weekday (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s3  (valid_s3),
		.total_s3  (total_s3),
		.valid_s4  (valid_s4),
		.result_s4 (result_s4)
	);

	// result word
	assign done   = valid_s4;
	assign result = result_s4;

	// every accepted word comes out with done high once it has passed all pipeline stages
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> ##4 done)
		else $error("result word missing four cycles after start");

	// an ordering is given only when both dates are valid
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((result.order == ORD_INVALID) == !(result.valid_a && result.valid_b)))
		else $error("order code disagrees with date validity");

	// invalid date A carries zero numeric fields
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.valid_a |->
			(result.serial_a == '0) && (result.year_day_a == '0) && (result.weekday_a == '0))
		else $error("invalid date A with nonzero fields");

	// valid date A has a day of year and weekday in range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.valid_a |->
			(result.year_day_a != '0) && (result.year_day_a <= 9'd366)
			&& (result.weekday_a <= 3'd6) && (result.serial_a != '0))
		else $error("valid date A with fields out of range");

endmodule
